>>> rtl/acm_pkg.sv
package acm_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_DEPTH = 32;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int POS_W     = 32;

    localparam logic [NODE_W-1:0] ROOT_NODE = '0;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_BUILD  = 2'd1,
        OP_SCAN   = 2'd2
    } t_op;

    typedef struct packed {
        logic [7:0]         sym;
        logic [NODE_W-1:0]  child;
        logic [NODE_W-1:0]  sibling;
        logic [NODE_W-1:0]  fail;
        logic               word_end;
        logic [DEPTH_W-1:0] depth;
    } t_node;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SR_RDP,
        S_SR_CHILD,
        S_SR_SIB,
        S_INS,
        S_INS_PAR,
        S_OVF,
        S_B_ROOT,
        S_B_RC,
        S_B_POP,
        S_B_V,
        S_B_VN,
        S_B_C,
        S_B_CN,
        S_B_G,
        S_B_SF,
        S_SC_G,
        S_SC_F,
        S_M_CHK,
        S_M_N,
        S_M_FLUSH
    } t_state;

endpackage

>>> rtl/aho_corasick_matcher.sv
// Multi-keyword matcher. One input channel carries requests (op, symbol, word_last) and
// one output channel carries results, both with valid/ready handshakes.
// An insert request adds one keyword byte to the trie; a build request computes the
// failure links and restarts the text position at zero; a scan request consumes one
// text byte and returns every keyword ending there, deepest first, the last one
// flagged with run_last. An insert into a full table, or beyond the maximum keyword
// depth, returns a single overflow result.
// All trie state sits in one node memory with a registered read, plus a queue memory
// used during build. Each request works through a sequence of reads on that single
// read port: an insert searches the children of its cursor sibling by sibling and
// creates a node when none matches; a scan tries nodes along the failure chain,
// searching the children of each, then walks the failure chain of the new node; a
// build visits every node in breadth-first order with child searches along each
// failure chain. One request is processed at a time.
// Results leave through an output register; while the receiver stalls, the block
// holds the pending result and waits. Requests are taken whenever the block is idle,
// even if a result is still waiting. After reset the trie holds only the root, the
// cursors point at the root and the text position is zero; no clearing pass is needed.
module aho_corasick_matcher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_op,
    input  logic [7:0]            i_symbol,
    input  logic                  i_word_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_kind,
    output logic [31:0]           o_match_start,
    output logic [31:0]           o_match_end,
    output logic                  o_run_last
);
    import acm_pkg::*;

    t_state r_state, n_state, r_ret, n_ret;
    logic [7:0]         r_sym, n_sym, r_ssym, n_ssym;
    logic               r_last, n_last;
    logic [NODE_W-1:0]  r_ins, n_ins, r_cur, n_cur, r_sp, n_sp, r_sc, n_sc;
    logic [NODE_W-1:0]  r_found, n_found, r_root_child, n_root_child;
    logic [NODE_W-1:0]  r_bc, n_bc, r_vfail, n_vfail, r_n, n_n;
    logic [NODE_W-1:0]  r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [POS_W-1:0]   r_pos, n_pos, r_pend_s, n_pend_s, r_pend_e, n_pend_e;
    logic               r_pend_v, n_pend_v;
    t_node              r_found_node, n_found_node, r_par_node, n_par_node;
    t_node              r_cnode, n_cnode;
    logic               r_out_valid, n_out_valid, r_kind, n_kind, r_run_last, n_run_last;
    logic [31:0]        r_out_s, n_out_s, r_out_e, n_out_e;

    t_node              r_node_mem [MAX_NODES];
    t_node              r_node_q;
    logic               r_rd_root;
    logic [NODE_W-1:0]  r_bfs_mem [MAX_NODES];
    logic [NODE_W-1:0]  r_bfs_q;

    logic               mem_re, mem_we, bq_re, bq_we;
    logic [NODE_W-1:0]  mem_ra, mem_wa;
    t_node              mem_wd, q, root_node;
    logic               accept, out_free, word_hit;
    logic [POS_W-1:0]   new_s, new_e;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_node_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_node_q  <= r_node_mem[mem_ra];
            r_rd_root <= (mem_ra == ROOT_NODE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (bq_we) begin
            r_bfs_mem[r_tail] <= r_bc;
        end
        if (bq_re) begin
            r_bfs_q <= r_bfs_mem[r_head];
        end
    end

    always_comb begin
        root_node          = '0;
        root_node.child    = r_root_child;
        q                  = r_rd_root ? root_node : r_node_q;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign word_hit   = q.word_end && r_pend_v;
    assign new_s      = r_pos - POS_W'(q.depth) + POS_W'(1);
    assign new_e      = r_pos + POS_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_op'(i_op))
                        OP_INSERT: n_state = S_SR_RDP;
                        OP_BUILD:  n_state = S_B_ROOT;
                        OP_SCAN:   n_state = S_SR_RDP;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SR_RDP:   n_state = S_SR_CHILD;
            S_SR_CHILD: n_state = (q.child == ROOT_NODE) ? r_ret : S_SR_SIB;
            S_SR_SIB: begin
                if (q.sym == r_ssym || q.sibling == ROOT_NODE) begin
                    n_state = r_ret;
                end
            end
            S_INS: begin
                if (r_found == ROOT_NODE) begin
                    if (r_count == CNT_W'(MAX_NODES) ||
                        r_par_node.depth >= DEPTH_W'(MAX_DEPTH)) begin
                        n_state = S_OVF;
                    end else begin
                        n_state = S_INS_PAR;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_INS_PAR: n_state = S_IDLE;
            S_OVF:     n_state = out_free ? S_IDLE : S_OVF;
            S_B_ROOT:  n_state = (r_bc == ROOT_NODE) ? S_B_POP : S_B_RC;
            S_B_RC:    n_state = S_B_ROOT;
            S_B_POP:   n_state = (r_head == r_tail) ? S_IDLE : S_B_V;
            S_B_V:     n_state = S_B_VN;
            S_B_VN:    n_state = S_B_C;
            S_B_C:     n_state = (r_bc == ROOT_NODE) ? S_B_POP : S_B_CN;
            S_B_CN:    n_state = S_SR_RDP;
            S_B_G: begin
                n_state = (r_found != ROOT_NODE || r_sp == ROOT_NODE) ? S_B_C : S_B_SF;
            end
            S_B_SF:    n_state = S_SR_RDP;
            S_SC_G: begin
                n_state = (r_found != ROOT_NODE || r_sp == ROOT_NODE) ? S_M_CHK : S_SC_F;
            end
            S_SC_F:    n_state = S_SR_RDP;
            S_M_CHK: begin
                if (r_n == ROOT_NODE) begin
                    n_state = r_pend_v ? S_M_FLUSH : S_IDLE;
                end else begin
                    n_state = S_M_N;
                end
            end
            S_M_N: begin
                if (!word_hit || out_free) begin
                    n_state = S_M_CHK;
                end
            end
            S_M_FLUSH: n_state = out_free ? S_IDLE : S_M_FLUSH;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ret        = r_ret;
        n_sym        = r_sym;
        n_last       = r_last;
        n_ssym       = r_ssym;
        n_ins        = r_ins;
        n_cur        = r_cur;
        n_sp         = r_sp;
        n_sc         = r_sc;
        n_found      = r_found;
        n_root_child = r_root_child;
        n_bc         = r_bc;
        n_vfail      = r_vfail;
        n_n          = r_n;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_pos        = r_pos;
        n_pend_v     = r_pend_v;
        n_pend_s     = r_pend_s;
        n_pend_e     = r_pend_e;
        n_found_node = r_found_node;
        n_par_node   = r_par_node;
        n_cnode      = r_cnode;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_kind       = r_kind;
        n_out_s      = r_out_s;
        n_out_e      = r_out_e;
        n_run_last   = r_run_last;
        mem_re       = 1'b0;
        mem_ra       = r_sp;
        mem_we       = 1'b0;
        mem_wa       = r_bc;
        mem_wd       = q;
        bq_re        = 1'b0;
        bq_we        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_sym    = i_symbol;
                    n_last   = i_word_last;
                    n_ssym   = i_symbol;
                    n_pend_v = 1'b0;
                    case (t_op'(i_op))
                        OP_INSERT: begin
                            n_sp  = r_ins;
                            n_ret = S_INS;
                        end
                        OP_BUILD: begin
                            n_bc   = r_root_child;
                            n_head = '0;
                            n_tail = '0;
                        end
                        OP_SCAN: begin
                            n_sp  = r_cur;
                            n_ret = S_SC_G;
                        end
                        default: begin
                            n_ret = r_ret;
                        end
                    endcase
                end
            end
            S_SR_RDP: begin
                mem_re = 1'b1;
                mem_ra = r_sp;
            end
            S_SR_CHILD: begin
                n_par_node = q;
                if (q.child == ROOT_NODE) begin
                    n_found = ROOT_NODE;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = q.child;
                    n_sc   = q.child;
                end
            end
            S_SR_SIB: begin
                if (q.sym == r_ssym) begin
                    n_found      = r_sc;
                    n_found_node = q;
                end else if (q.sibling == ROOT_NODE) begin
                    n_found = ROOT_NODE;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = q.sibling;
                    n_sc   = q.sibling;
                end
            end
            S_INS: begin
                if (r_found == ROOT_NODE) begin
                    if (r_count == CNT_W'(MAX_NODES) ||
                        r_par_node.depth >= DEPTH_W'(MAX_DEPTH)) begin
                        n_ins = ROOT_NODE;
                    end else begin
                        mem_we          = 1'b1;
                        mem_wa          = r_count[NODE_W-1:0];
                        mem_wd.sym      = r_sym;
                        mem_wd.child    = ROOT_NODE;
                        mem_wd.sibling  = r_par_node.child;
                        mem_wd.fail     = ROOT_NODE;
                        mem_wd.word_end = r_last;
                        mem_wd.depth    = r_par_node.depth + DEPTH_W'(1);
                        n_count         = r_count + CNT_W'(1);
                        n_found         = r_count[NODE_W-1:0];
                        n_ins           = r_last ? ROOT_NODE : r_count[NODE_W-1:0];
                    end
                end else begin
                    if (r_last) begin
                        mem_we          = 1'b1;
                        mem_wa          = r_found;
                        mem_wd          = r_found_node;
                        mem_wd.word_end = 1'b1;
                    end
                    n_ins = r_last ? ROOT_NODE : r_found;
                end
            end
            S_INS_PAR: begin
                if (r_sp == ROOT_NODE) begin
                    n_root_child = r_found;
                end else begin
                    mem_we       = 1'b1;
                    mem_wa       = r_sp;
                    mem_wd       = r_par_node;
                    mem_wd.child = r_found;
                end
            end
            S_OVF: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = 1'b1;
                    n_out_s     = '0;
                    n_out_e     = '0;
                    n_run_last  = 1'b1;
                end
            end
            S_B_ROOT: begin
                if (r_bc != ROOT_NODE) begin
                    mem_re = 1'b1;
                    mem_ra = r_bc;
                end
            end
            S_B_RC: begin
                mem_we      = 1'b1;
                mem_wa      = r_bc;
                mem_wd      = q;
                mem_wd.fail = ROOT_NODE;
                bq_we       = 1'b1;
                n_tail      = r_tail + NODE_W'(1);
                n_bc        = q.sibling;
            end
            S_B_POP: begin
                if (r_head == r_tail) begin
                    n_ins = ROOT_NODE;
                    n_cur = ROOT_NODE;
                    n_pos = '0;
                end else begin
                    bq_re  = 1'b1;
                    n_head = r_head + NODE_W'(1);
                end
            end
            S_B_V: begin
                mem_re = 1'b1;
                mem_ra = r_bfs_q;
            end
            S_B_VN: begin
                n_vfail = q.fail;
                n_bc    = q.child;
            end
            S_B_C: begin
                if (r_bc != ROOT_NODE) begin
                    mem_re = 1'b1;
                    mem_ra = r_bc;
                end
            end
            S_B_CN: begin
                n_cnode = q;
                bq_we   = 1'b1;
                n_tail  = r_tail + NODE_W'(1);
                n_sp    = r_vfail;
                n_ssym  = q.sym;
                n_ret   = S_B_G;
            end
            S_B_G: begin
                if (r_found != ROOT_NODE || r_sp == ROOT_NODE) begin
                    mem_we      = 1'b1;
                    mem_wa      = r_bc;
                    mem_wd      = r_cnode;
                    mem_wd.fail = r_found;
                    n_bc        = r_cnode.sibling;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = r_sp;
                end
            end
            S_B_SF: begin
                n_sp = q.fail;
            end
            S_SC_G: begin
                if (r_found != ROOT_NODE || r_sp == ROOT_NODE) begin
                    n_cur = r_found;
                    n_n   = r_found;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = r_sp;
                end
            end
            S_SC_F: begin
                n_sp = q.fail;
            end
            S_M_CHK: begin
                if (r_n == ROOT_NODE) begin
                    if (!r_pend_v) begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end else begin
                    mem_re = 1'b1;
                    mem_ra = r_n;
                end
            end
            S_M_N: begin
                if (word_hit) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_kind      = 1'b0;
                        n_out_s     = r_pend_s;
                        n_out_e     = r_pend_e;
                        n_run_last  = 1'b0;
                        n_pend_s    = new_s;
                        n_pend_e    = new_e;
                        n_n         = q.fail;
                    end
                end else begin
                    if (q.word_end) begin
                        n_pend_v = 1'b1;
                        n_pend_s = new_s;
                        n_pend_e = new_e;
                    end
                    n_n = q.fail;
                end
            end
            S_M_FLUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = 1'b0;
                    n_out_s     = r_pend_s;
                    n_out_e     = r_pend_e;
                    n_run_last  = 1'b1;
                    n_pos       = r_pos + POS_W'(1);
                end
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_count      <= CNT_W'(1);
            r_root_child <= ROOT_NODE;
            r_ins        <= ROOT_NODE;
            r_cur        <= ROOT_NODE;
            r_pos        <= '0;
            r_pend_v     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_count      <= n_count;
            r_root_child <= n_root_child;
            r_ins        <= n_ins;
            r_cur        <= n_cur;
            r_pos        <= n_pos;
            r_pend_v     <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret        <= n_ret;
        r_sym        <= n_sym;
        r_last       <= n_last;
        r_ssym       <= n_ssym;
        r_sp         <= n_sp;
        r_sc         <= n_sc;
        r_found      <= n_found;
        r_bc         <= n_bc;
        r_vfail      <= n_vfail;
        r_n          <= n_n;
        r_head       <= n_head;
        r_tail       <= n_tail;
        r_pend_s     <= n_pend_s;
        r_pend_e     <= n_pend_e;
        r_found_node <= n_found_node;
        r_par_node   <= n_par_node;
        r_cnode      <= n_cnode;
        r_kind       <= n_kind;
        r_out_s      <= n_out_s;
        r_out_e      <= n_out_e;
        r_run_last   <= n_run_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_match_start = r_out_s;
    assign o_match_end   = r_out_e;
    assign o_run_last    = r_run_last;

endmodule

>>> tb/acm_checker.sv
module acm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_symbol,
    input  logic        i_word_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_kind,
    input  logic [31:0] i_match_start,
    input  logic [31:0] i_match_end,
    input  logic        i_run_last,
    output int          o_errors,
    output int          o_pending
);
    import acm_pkg::*;

    localparam int unsigned ROOT = ROOT_NODE;
    localparam bit KIND_MATCH    = 1'b0;
    localparam bit KIND_OVERFLOW = 1'b1;

    typedef struct {
        bit          kind;
        logic [31:0] first;
        logic [31:0] stop;
        bit          last;
    } t_hit;

    logic [7:0]  trie_sym   [MAX_NODES];
    int unsigned trie_child [MAX_NODES];
    int unsigned trie_sib   [MAX_NODES];
    int unsigned trie_fail  [MAX_NODES];
    bit          trie_word  [MAX_NODES];
    int unsigned trie_depth [MAX_NODES];
    int unsigned bfs_order  [MAX_NODES];
    int unsigned used_nodes;
    int unsigned key_cursor;
    int unsigned text_state;
    logic [31:0] text_pos;
    t_hit        hits_q[$];
    int          errors = 0;

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic clear_trie();
        for (int i = 0; i < MAX_NODES; i++) begin
            trie_sym[i] = '0;
            trie_child[i] = ROOT;
            trie_sib[i] = ROOT;
            trie_fail[i] = ROOT;
            trie_word[i] = 1'b0;
            trie_depth[i] = 0;
        end
        used_nodes = 1;
        key_cursor = ROOT;
        text_state = ROOT;
        text_pos = '0;
        hits_q.delete();
    endtask

    function automatic int unsigned child_with(int unsigned n, logic [7:0] s);
        int unsigned c;
        int guard;
        c = trie_child[n];
        guard = 0;
        while (c != ROOT && guard < MAX_NODES) begin
            if (trie_sym[c] == s) return c;
            c = trie_sib[c];
            guard++;
        end
        return ROOT;
    endfunction

    task automatic link_failures();
        int unsigned head, tail, c, v, s, g, hops;
        int guard;
        head = 0;
        tail = 0;
        trie_fail[ROOT] = ROOT;
        c = trie_child[ROOT];
        guard = 0;
        while (c != ROOT && guard < MAX_NODES) begin
            trie_fail[c] = ROOT;
            if (tail < MAX_NODES) bfs_order[tail++] = c;
            c = trie_sib[c];
            guard++;
        end
        while (head < tail) begin
            v = bfs_order[head++];
            c = trie_child[v];
            guard = 0;
            while (c != ROOT && guard < MAX_NODES) begin
                s = trie_fail[v];
                hops = 0;
                if (tail < MAX_NODES) bfs_order[tail++] = c;
                forever begin
                    g = child_with(s, trie_sym[c]);
                    if (g != ROOT || s == ROOT || hops > MAX_DEPTH) break;
                    s = trie_fail[s];
                    hops++;
                end
                trie_fail[c] = g;
                c = trie_sib[c];
                guard++;
            end
        end
        key_cursor = ROOT;
        text_state = ROOT;
        text_pos = '0;
    endtask

    task automatic add_key_byte(input logic [7:0] s, input bit last);
        int unsigned cur, nx;
        t_hit h;
        cur = key_cursor;
        nx = child_with(cur, s);
        if (nx == ROOT) begin
            if (used_nodes >= MAX_NODES || trie_depth[cur] >= MAX_DEPTH) begin
                key_cursor = ROOT;
                h = '{KIND_OVERFLOW, 32'd0, 32'd0, 1'b1};
                hits_q = {hits_q, h};
                return;
            end
            nx = used_nodes++;
            trie_sym[nx] = s;
            trie_child[nx] = ROOT;
            trie_sib[nx] = trie_child[cur];
            trie_fail[nx] = ROOT;
            trie_word[nx] = 1'b0;
            trie_depth[nx] = trie_depth[cur] + 1;
            trie_child[cur] = nx;
        end
        if (last) begin
            trie_word[nx] = 1'b1;
            key_cursor = ROOT;
        end else begin
            key_cursor = nx;
        end
    endtask

    task automatic scan_text_byte(input logic [7:0] s);
        int unsigned pa, ch, n, hops;
        int k;
        t_hit h;
        pa = text_state;
        hops = 0;
        k = 0;
        while (pa != ROOT && child_with(pa, s) == ROOT && hops <= MAX_DEPTH) begin
            pa = trie_fail[pa];
            hops++;
        end
        ch = child_with(pa, s);
        if (ch != ROOT) pa = ch;
        text_state = pa;
        n = pa;
        hops = 0;
        while (n != ROOT && hops <= MAX_DEPTH && k < 32) begin
            if (trie_word[n]) begin
                h = '{KIND_MATCH, text_pos - 32'(trie_depth[n]) + 32'd1, text_pos + 32'd1, 1'b0};
                hits_q = {hits_q, h};
                k++;
            end
            n = trie_fail[n];
            hops++;
        end
        if (k > 0) hits_q[hits_q.size() - 1].last = 1'b1;
        text_pos = text_pos + 32'd1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_trie();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (hits_q.size() == 0) begin
                    report($sformatf("unexpected result kind=%0d start=%0d end=%0d",
                                     i_kind, i_match_start, i_match_end));
                end else begin
                    t_hit h;
                    h = hits_q.pop_front();
                    if (i_kind !== h.kind)
                        report($sformatf("kind %0d, expected %0d", i_kind, h.kind));
                    if (i_match_start !== h.first)
                        report($sformatf("match_start %0d, expected %0d",
                                         i_match_start, h.first));
                    if (i_match_end !== h.stop)
                        report($sformatf("match_end %0d, expected %0d", i_match_end, h.stop));
                    if (i_run_last !== h.last)
                        report($sformatf("run_last %0d, expected %0d", i_run_last, h.last));
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_op)
                    OP_INSERT: add_key_byte(i_symbol, i_word_last);
                    OP_BUILD:  link_failures();
                    OP_SCAN:   scan_text_byte(i_symbol);
                    default: ;
                endcase
            end
        end
        o_pending = hits_q.size();
        o_errors = errors;
    end

endmodule

>>> tb/tb_aho_corasick_matcher.sv
module tb_aho_corasick_matcher;
    import acm_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic [7:0]  i_symbol;
    logic        i_word_last;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_kind;
    logic [31:0] o_match_start;
    logic [31:0] o_match_end;
    logic        o_run_last;
    int          errors;
    int          pending;
    bit          no_idle;
    bit          stall_now;
    bit          stall_taken;
    int          cycles;

    aho_corasick_matcher dut (.*);

    acm_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_op(i_op), .i_symbol(i_symbol), .i_word_last(i_word_last),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_kind(o_kind), .i_match_start(o_match_start), .i_match_end(o_match_end),
        .i_run_last(o_run_last), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // The receiver makes random short hold-offs, and one long hold-off on request.
    initial begin
        i_out_ready <= 1'b0;
        stall_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_now && !stall_taken) begin
                stall_taken = 1'b1;
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send(input logic [1:0] op, input logic [7:0] sym, input bit last);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_symbol <= sym;
        i_word_last <= last;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic add_keyword(input string w);
        for (int i = 0; i < w.len(); i++) send(OP_INSERT, w[i], i == w.len() - 1);
    endtask

    task automatic add_run(input logic [7:0] sym, input int n);
        for (int i = 0; i < n; i++) send(OP_INSERT, sym, i == n - 1);
    endtask

    task automatic scan_string(input string w);
        for (int i = 0; i < w.len(); i++) send(OP_SCAN, w[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_sym();
        if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
        return 8'("a") + 8'($urandom_range(0, 3));
    endfunction

    initial begin
        int len, n_keys, n_text, sent;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_op <= OP_INSERT;
        i_symbol <= '0;
        i_word_last <= 1'b0;
        no_idle = 1'b0;
        stall_now = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_keyword("he");
        add_keyword("she");
        add_keyword("his");
        add_keyword("hers");
        send(OP_INSERT, 8'h00, 1'b0);
        send(OP_INSERT, 8'hff, 1'b1);
        send(OP_UNUSED, 8'h55, 1'b1);
        send(OP_BUILD, 8'haa, 1'b0);
        scan_string("ushers");
        send(OP_SCAN, 8'h00, 1'b1);
        send(OP_SCAN, 8'hff, 1'b0);
        send(OP_INSERT, "s", 1'b0);
        send(OP_INSERT, "h", 1'b1);
        scan_string("sh");
        drain();

        // Nested keywords of one repeated byte give a long failure chain of word ends.
        for (int k = 1; k <= 6; k++) add_run("q", k);
        add_run("q", MAX_DEPTH + 1);
        send(OP_BUILD, 8'h00, 1'b0);
        stall_now = 1'b1;
        for (int i = 0; i < 30; i++) send(OP_SCAN, "q", 1'b0);
        drain();

        sent = 0;
        while (sent < 80) begin
            n_keys = $urandom_range(1, 5);
            for (int k = 0; k < n_keys; k++) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    send(OP_INSERT, pick_sym(),
                         (i == len - 1) && ($urandom_range(0, 9) != 0));
                    sent++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    send(OP_UNUSED, 8'($urandom), 1'($urandom));
                    sent++;
                end
            end
            if ($urandom_range(0, 4) != 0) begin
                send(OP_BUILD, 8'($urandom), 1'($urandom));
                sent++;
            end
            n_text = $urandom_range(5, 25);
            for (int i = 0; i < n_text; i++) begin
                send(OP_SCAN, pick_sym(), 1'($urandom));
                sent++;
            end
            if ($urandom_range(0, 7) == 0) drain();
        end

        // A deep keyword from a small alphabet, then text over the same alphabet.
        no_idle = 1'b1;
        for (int i = 0; i < MAX_DEPTH; i++)
            send(OP_INSERT, 8'($urandom_range(8'h30, 8'h3f)), i == MAX_DEPTH - 1);
        send(OP_BUILD, 8'h00, 1'b0);
        for (int i = 0; i < 20; i++) send(OP_SCAN, 8'($urandom_range(8'h30, 8'h3f)), 1'b0);
        scan_string("ushersqqq");
        drain();

        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/acm_pkg.sv
rtl/aho_corasick_matcher.sv
tb/acm_checker.sv
tb/tb_aho_corasick_matcher.sv
